// ===== rtl/core/sswt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sequence window tracker package
// Shared widths, status and reason codes, and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package sswt_pkg;
  localparam int unsigned Streams          = 16;
  localparam int unsigned IdxW             = $clog2(Streams);
  localparam int unsigned CntW             = $clog2(Streams + 1);
  localparam int unsigned EventCapacity    = 256;
  localparam int unsigned ConflictCapacity = 64;
  localparam int unsigned AccW             = $clog2(EventCapacity + 1);
  localparam int unsigned QuaW             = $clog2(ConflictCapacity + 1);
  localparam int unsigned WinMax           = 64;
  localparam int unsigned KeyW             = 288;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StInvalid    = 2'd1,
    StCapacity   = 2'd2,
    StQuarantine = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RsNone      = 2'd0,
    RsCollision = 2'd1,
    RsWindow    = 2'd2
  } reason_e;

  typedef struct packed {
    logic        incomplete;
    logic [31:0] first_missing;
    logic [31:0] highest_seen;
    logic [31:0] contiguous_mark;
    reason_e     reason;
    status_e     status;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/core/sswt_window.sv =====
// ----------------------------------------------------------------------------
// Sequence window entry engine
// Holds the per-stream window state and advances the contiguous mark by one
// sequence per cycle over the pending bitmap.
// ----------------------------------------------------------------------------
`default_nettype none
module sswt_window (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    alloc_i,
  input  wire logic [sswt_pkg::IdxW-1:0] idx_i,
  input  wire logic [31:0]             seq_i,
  input  wire logic [6:0]              win_i,
  input  wire logic                    q_full_i,
  output logic                         done_o,
  output logic                         accept_o,
  output sswt_pkg::result_t            res_o
);
  typedef enum logic [1:0] {WIdle, WLoad, WEval, WShift} wstate_e;

  logic [31:0] cont_q [sswt_pkg::Streams];
  logic [31:0] seen_q [sswt_pkg::Streams];
  logic [63:0] pend_q [sswt_pkg::Streams];
  logic        inc_q  [sswt_pkg::Streams];

  wstate_e     state_q;
  logic [31:0] cont_w, seen_w;
  logic [63:0] pend_w;
  logic        inc_w;
  logic        done_q, accept_q;
  sswt_pkg::result_t res_q;
  logic [31:0] delta;
  logic [6:0]  win;

  assign win   = (win_i > 7'(sswt_pkg::WinMax)) ? 7'(sswt_pkg::WinMax) : win_i;
  assign delta = seq_i - cont_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= WIdle;
      done_q   <= 1'b0;
      accept_q <= 1'b0;
    end else begin
      done_q   <= (state_q == WShift) && !pend_w[0];
      accept_q <= (state_q == WEval) && (seq_i > cont_w) && (delta <= 32'(win));
      unique case (state_q)
        WIdle: if (start_i) state_q <= WLoad;
        WLoad: begin
          if (alloc_i) begin
            cont_w <= '0; seen_w <= '0; pend_w <= '0; inc_w <= 1'b0;
          end else begin
            cont_w <= cont_q[idx_i]; seen_w <= seen_q[idx_i];
            pend_w <= pend_q[idx_i]; inc_w <= inc_q[idx_i];
          end
          state_q <= WEval;
        end
        WEval: begin
          if (seq_i <= cont_w) begin
            res_q.status <= q_full_i ? sswt_pkg::StCapacity : sswt_pkg::StQuarantine;
            res_q.reason <= q_full_i ? sswt_pkg::RsNone : sswt_pkg::RsCollision;
            state_q <= WShift;
          end else if (delta > 32'(win)) begin
            inc_w <= 1'b1;
            if (seq_i > seen_w) seen_w <= seq_i;
            res_q.status <= q_full_i ? sswt_pkg::StCapacity : sswt_pkg::StQuarantine;
            res_q.reason <= q_full_i ? sswt_pkg::RsNone : sswt_pkg::RsWindow;
            state_q <= WShift;
          end else begin
            pend_w <= pend_w | (64'd1 << (delta[5:0] - 6'd1));
            if (seq_i > seen_w) seen_w <= seq_i;
            res_q.status <= sswt_pkg::StOk;
            res_q.reason <= sswt_pkg::RsNone;
            state_q      <= WShift;
          end
        end
        WShift: begin
          if (pend_w[0]) begin
            cont_w <= cont_w + 32'd1;
            pend_w <= pend_w >> 1;
          end else begin
            if (res_q.status == sswt_pkg::StOk) inc_w <= seen_w > cont_w;
            cont_q[idx_i] <= cont_w;
            seen_q[idx_i] <= seen_w;
            pend_q[idx_i] <= pend_w;
            inc_q[idx_i]  <= (res_q.status == sswt_pkg::StOk) ? (seen_w > cont_w) : inc_w;
            res_q.contiguous_mark <= cont_w;
            res_q.highest_seen    <= seen_w;
            res_q.first_missing   <= (seen_w > cont_w) ? cont_w + 32'd1 : '0;
            res_q.incomplete      <= (res_q.status == sswt_pkg::StOk) ?
                                     (seen_w > cont_w) : inc_w;
            state_q <= WIdle;
          end
        end
        default: state_q <= WIdle;
      endcase
    end
  end

  assign done_o   = done_q;
  assign accept_o = accept_q;
  assign res_o    = res_q;
endmodule
`default_nettype wire

// ===== rtl/core/sender_sequence_window_tracker.sv =====
// ----------------------------------------------------------------------------
// Sender sequence window tracker
// Per-stream anti-replay window: key search, allocation and mark advance.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   tdata: group_hi, group_lo, sender_hi, sender_lo, epoch, seq
// m_axis    out  tdata: status, reason, mark, seen, first_missing, incomplete
// cfg       in   window_size (7 bits)
// An item passes through a search of the table, one entry compared per step
// and then a hit or an allocation, and then through the window engine, which
// advances the mark one sequence per cycle. A zero sequence or a full event
// count skips the search and the engine, and a full table skips the engine.
// Reset empties the table. The input waits while a result is held.
// ----------------------------------------------------------------------------
`default_nettype none
module sender_sequence_window_tracker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // group_hi, group_lo, sender_hi, sender_lo, epoch_number, sequence_req
  input  wire logic [319:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, reason, contiguous_mark, highest_seen, first_missing,
  // stream_incomplete, zero fill
  output logic [103:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [6:0]   cfg_data_i
);
  typedef enum logic [2:0] {Idle, Search, Engine, Wait, Out} state_e;

  state_e state_q;
  logic [sswt_pkg::KeyW-1:0] key_q;
  logic [sswt_pkg::KeyW-1:0] keys_q [sswt_pkg::Streams];
  logic [31:0] seq_q;
  logic [6:0]  win_q;
  logic [sswt_pkg::CntW-1:0] used_q, scan_q;
  logic [sswt_pkg::IdxW-1:0] idx_q;
  logic [sswt_pkg::AccW-1:0] acc_q;
  logic [sswt_pkg::QuaW-1:0] qua_q;
  logic alloc_q, start_q, valid_q;
  sswt_pkg::result_t out_q, eng_res, early_res;
  logic eng_done, eng_acc;
  logic key_hit;

  sswt_window u_win (
    .clk_i, .rst_ni, .start_i(start_q), .alloc_i(alloc_q), .idx_i(idx_q),
    .seq_i(seq_q), .win_i(win_q),
    .q_full_i(qua_q >= sswt_pkg::QuaW'(sswt_pkg::ConflictCapacity)),
    .done_o(eng_done), .accept_o(eng_acc), .res_o(eng_res));

  assign s_axis_tready = (state_q == Idle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {3'b000, out_q.incomplete, out_q.first_missing, out_q.highest_seen,
                          out_q.contiguous_mark, out_q.reason, out_q.status};
  assign key_hit       = (keys_q[scan_q[sswt_pkg::IdxW-1:0]] == key_q);

  always_comb begin
    early_res        = '0;
    early_res.status = (s_axis_tdata[319:288] == 32'd0) ? sswt_pkg::StInvalid
                                                        : sswt_pkg::StCapacity;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; used_q <= '0; acc_q <= '0; qua_q <= '0;
      win_q <= 7'd64; start_q <= 1'b0; valid_q <= 1'b0;
    end else begin
      start_q <= (state_q == Search) &&
                 ((scan_q == used_q) ? (used_q < sswt_pkg::CntW'(sswt_pkg::Streams))
                                     : key_hit);
      if (cfg_valid_i) win_q <= cfg_data_i;
      unique case (state_q)
        Idle: if (s_axis_tvalid) begin
          key_q  <= s_axis_tdata[287:0];
          seq_q  <= s_axis_tdata[319:288];
          scan_q <= '0;
          out_q  <= early_res;
          if (s_axis_tdata[319:288] == 32'd0) begin
            state_q <= Out;
          end else if (acc_q >= sswt_pkg::AccW'(sswt_pkg::EventCapacity)) begin
            state_q <= Out;
          end else state_q <= Search;
        end
        Search: begin
          if (scan_q == used_q) begin
            if (used_q >= sswt_pkg::CntW'(sswt_pkg::Streams)) begin
              out_q.status <= sswt_pkg::StCapacity; state_q <= Out;
            end else begin
              keys_q[used_q[sswt_pkg::IdxW-1:0]] <= key_q;
              idx_q <= used_q[sswt_pkg::IdxW-1:0];
              used_q <= used_q + sswt_pkg::CntW'(1);
              alloc_q <= 1'b1; state_q <= Engine;
            end
          end else if (key_hit) begin
            idx_q <= scan_q[sswt_pkg::IdxW-1:0];
            alloc_q <= 1'b0; state_q <= Engine;
          end else scan_q <= scan_q + sswt_pkg::CntW'(1);
        end
        Engine: state_q <= Wait;
        Wait: begin
          if (eng_acc) acc_q <= acc_q + sswt_pkg::AccW'(1);
          if (eng_done) begin
            out_q <= eng_res;
            if (eng_res.status == sswt_pkg::StQuarantine) qua_q <= qua_q + sswt_pkg::QuaW'(1);
            state_q <= Out;
          end
        end
        Out: begin
          valid_q <= !(valid_q && m_axis_tready);
          if (valid_q && m_axis_tready) state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= sswt_pkg::CntW'(sswt_pkg::Streams)) else $error("table overfilled");
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= sswt_pkg::AccW'(sswt_pkg::EventCapacity)) else $error("event count overrun");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepting while result held");
`endif
endmodule
`default_nettype wire
